// ===== rtl/blr_pkg.sv =====
// shared types and constants for the line rasterizer
// no dependencies
package blr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int COLOR_BITS  = 16;
  localparam int SCREEN_BITS = 11;
  localparam int CFG_IDX_BITS = 1;

  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = SCREEN_BITS'(240);
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = SCREEN_BITS'(320);

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic [SCREEN_BITS-1:0]     screen_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } item_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   on_screen;
    logic   last_pixel;
  } pix_t;

endpackage

// ===== rtl/blr_in_stage.sv =====
// input register of the line rasterizer
// depends on blr_pkg
module blr_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  blr_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output blr_pkg::item_t item
);

  logic           valid_r, valid_nxt;
  blr_pkg::item_t item_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/blr_core.sv =====
// line state, bresenham step and screen registers
// depends on blr_pkg
module blr_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [blr_pkg::SCREEN_BITS-1:0]      cfg_data,
  input  logic                                 fire,
  input  blr_pkg::item_t                       item,
  output logic                                 res_valid,
  output blr_pkg::pix_t                        res
);

  localparam int CB = blr_pkg::COORD_BITS;

  logic             active_r, active_nxt;
  blr_pkg::coord_t  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  blr_pkg::coord_t  tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  blr_pkg::coord_t  adx_r, adx_nxt, ady_r, ady_nxt;
  logic             xdown_r, xdown_nxt, ydown_r, ydown_nxt;
  blr_pkg::err_t    err_r, err_nxt;
  blr_pkg::color_t  color_r, color_nxt;
  blr_pkg::screen_t width_r, height_r;

  blr_pkg::coord_t  s_adx, s_ady, step_x, step_y;
  logic             s_xback, s_yback, s_xmajor, x_major, last;
  blr_pkg::err_t    two_dx, two_dy, s_two_dx, s_two_dy, s_dx, s_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= blr_pkg::SCREEN_WIDTH_RST;
      height_r <= blr_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        blr_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
        blr_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // start item setup
  assign s_xback  = item.end_x < item.start_x;
  assign s_yback  = item.end_y < item.start_y;
  assign s_adx    = s_xback ? item.start_x - item.end_x : item.end_x - item.start_x;
  assign s_ady    = s_yback ? item.start_y - item.end_y : item.end_y - item.start_y;
  assign s_xmajor = s_adx > s_ady;
  assign s_two_dx = {2'b00, s_adx, 1'b0};
  assign s_two_dy = {2'b00, s_ady, 1'b0};
  assign s_dx     = {3'b000, s_adx};
  assign s_dy     = {3'b000, s_ady};

  // advance step
  assign x_major = adx_r > ady_r;
  assign last    = x_major ? (cur_x_r == tgt_x_r) : (cur_y_r == tgt_y_r);
  assign step_x  = xdown_r ? cur_x_r - CB'(1) : cur_x_r + CB'(1);
  assign step_y  = ydown_r ? cur_y_r - CB'(1) : cur_y_r + CB'(1);
  assign two_dx  = {2'b00, adx_r, 1'b0};
  assign two_dy  = {2'b00, ady_r, 1'b0};

  always_comb begin
    res.pixel_x     = cur_x_r;
    res.pixel_y     = cur_y_r;
    res.pixel_color = color_r;
    res.on_screen   = ({1'b0, cur_x_r} < width_r) && ({1'b0, cur_y_r} < height_r);
    res.last_pixel  = last;
  end

  always_comb begin
    active_nxt = active_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    adx_nxt    = adx_r;
    ady_nxt    = ady_r;
    xdown_nxt  = xdown_r;
    ydown_nxt  = ydown_r;
    err_nxt    = err_r;
    color_nxt  = color_r;
    res_valid  = 1'b0;
    if (fire) begin
      if (item.mode == blr_pkg::MODE_START) begin
        active_nxt = 1'b1;
        cur_x_nxt  = item.start_x;
        cur_y_nxt  = item.start_y;
        tgt_x_nxt  = item.end_x;
        tgt_y_nxt  = item.end_y;
        adx_nxt    = s_adx;
        ady_nxt    = s_ady;
        xdown_nxt  = s_xback;
        ydown_nxt  = s_yback;
        err_nxt    = s_xmajor ? s_two_dy - s_dx : s_two_dx - s_dy;
        color_nxt  = item.line_color;
      end else if (active_r) begin
        res_valid = 1'b1;
        if (last) begin
          active_nxt = 1'b0;
        end else if (x_major) begin
          cur_x_nxt = step_x;
          if (err_r > 0) begin
            cur_y_nxt = step_y;
            err_nxt   = err_r + two_dy - two_dx;
          end else begin
            err_nxt = err_r + two_dy;
          end
        end else begin
          cur_y_nxt = step_y;
          if (err_r > 0) begin
            cur_x_nxt = step_x;
            err_nxt   = err_r + two_dx - two_dy;
          end else begin
            err_nxt = err_r + two_dx;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      tgt_x_r  <= '0;
      tgt_y_r  <= '0;
      adx_r    <= '0;
      ady_r    <= '0;
      xdown_r  <= 1'b0;
      ydown_r  <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
    end else begin
      active_r <= active_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      adx_r    <= adx_nxt;
      ady_r    <= ady_nxt;
      xdown_r  <= xdown_nxt;
      ydown_r  <= ydown_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
    end
  end

endmodule

// ===== rtl/blr_out_stage.sv =====
// result register of the line rasterizer
// depends on blr_pkg
module blr_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  blr_pkg::pix_t res,
  output logic          take,
  output logic          out_tvalid,
  input  logic          out_tready,
  output blr_pkg::pix_t out_pix
);

  logic          valid_r, valid_nxt;
  blr_pkg::pix_t pix_r;

  assign take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = take ? res_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      pix_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_pix    = pix_r;

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// bresenham line rasterizer top level
// path: an accepted advance beat is registered in blr_in_stage and its pixel in blr_out_stage
// throughput: one beat per cycle while out_tready does not stall the result stage, set by the step in blr_core
// reset: synchronous active low; line idle, screen 240 x 320, both stages empty
// depends on blr_pkg, blr_in_stage, blr_core, blr_out_stage
module bresenham_line_rasterizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [blr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [blr_pkg::SCREEN_BITS-1:0]      cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [blr_pkg::IN_DATA_BITS-1:0]     in_tdata,
  // mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [blr_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  // on_screen
  output logic                                 out_tuser,
  output logic                                 out_tlast
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int KB = blr_pkg::COLOR_BITS;

  blr_pkg::item_t in_item, item;
  blr_pkg::pix_t  res, out_pix;
  logic           item_valid, take, res_valid;

  always_comb begin
    in_item.mode       = in_tuser;
    in_item.start_x    = in_tdata[CB-1:0];
    in_item.start_y    = in_tdata[2*CB-1:CB];
    in_item.end_x      = in_tdata[3*CB-1:2*CB];
    in_item.end_y      = in_tdata[4*CB-1:3*CB];
    in_item.line_color = in_tdata[4*CB+KB-1:4*CB];
  end

  blr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  blr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (item_valid && take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  blr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pix    (out_pix)
  );

  assign out_tdata = blr_pkg::OUT_DATA_BITS'({out_pix.pixel_color, out_pix.pixel_y,
                                              out_pix.pixel_x});
  assign out_tuser = out_pix.on_screen;
  assign out_tlast = out_pix.last_pixel;

endmodule

// ===== rtl/blr_checker.sv =====
// port-level checks for the line rasterizer, bound to the top level
// depends on blr_pkg and bresenham_line_rasterizer
module blr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("pixel beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("pixel beat present after reset");

  a_pixel_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser == blr_pkg::MODE_ADVANCE, 2))
    else $error("pixel beat without an advance beat two cycles earlier");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result stage");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);
